FILE: rtl/core/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants of the trigram set extractor.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int unsigned MAX_DISTINCT_DEF = 65536;
  localparam logic [15:0] DISTINCT_LIMIT_RST = 16'd4096;

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_DISTINCT_LIMIT = 2'd0;

  // seen bitmap: 2^24 bits held as 64-bit rows
  localparam int unsigned TRI_W      = 24;
  localparam int unsigned BMP_ROW_W  = 64;
  localparam int unsigned BMP_BIT_W  = $clog2(BMP_ROW_W);
  localparam int unsigned BMP_ROW_AW = TRI_W - BMP_BIT_W;
  localparam int unsigned BMP_ROWS   = 1 << BMP_ROW_AW;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [1:0] KIND_NEW       = 2'd0;
  localparam logic [1:0] KIND_DONE      = 2'd1;
  localparam logic [1:0] KIND_OVERSIZED = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       file_start;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic [TRI_W-1:0] trigram;
    logic [1:0]       kind;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic             file_start;
    logic             byte_valid;
    logic             file_end;
    logic [TRI_W-1:0] trigram;
  } tse_cmd_t;

endpackage

FILE: rtl/core/tse_front.sv
// ----------------------------------------------------------------------------
// tse_front
// Accepts input transactions, keeps the byte window and forms trigram commands.
// ----------------------------------------------------------------------------
module tse_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tse_pkg::in_item_t  in_data,
  input  logic               init_done,
  input  logic               q_full,
  output logic               q_push,
  output tse_pkg::tse_cmd_t  q_cmd
);

  logic [15:0] window_r;
  logic [15:0] window_nxt;
  logic [15:0] win_base;
  logic [tse_pkg::TRI_W-1:0] tri_w;

  assign in_ready = init_done && !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    win_base = in_data.file_start ? 16'd0 : window_r;
    tri_w    = {win_base, in_data.data_byte};
    window_nxt = in_data.byte_valid ? tri_w[15:0] : win_base;
    q_cmd.file_start = in_data.file_start;
    q_cmd.byte_valid = in_data.byte_valid;
    q_cmd.file_end   = in_data.file_end;
    q_cmd.trigram    = tri_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= 16'd0;
    end else if (q_push) begin
      window_r <= window_nxt;
    end
  end

endmodule

FILE: rtl/core/tse_queue.sv
// ----------------------------------------------------------------------------
// tse_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module tse_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tse_pkg::tse_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tse_pkg::tse_cmd_t head_cmd
);

  tse_pkg::tse_cmd_t          q_mem [tse_pkg::Q_DEPTH];
  logic [tse_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [tse_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [tse_pkg::Q_PTR_W:0]   fill_r;
  logic [tse_pkg::Q_PTR_W:0]   fill_nxt;

  assign full       = (fill_r == (tse_pkg::Q_PTR_W+1)'(tse_pkg::Q_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_cmd   = q_mem[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

FILE: rtl/core/tse_back.sv
// ----------------------------------------------------------------------------
// tse_back
// Sequencer over the seen bitmap and inserted list; emits result transactions.
// ----------------------------------------------------------------------------
module tse_back #(
  parameter int unsigned MAX_DISTINCT = tse_pkg::MAX_DISTINCT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         distinct_limit,
  input  logic                q_valid,
  input  tse_pkg::tse_cmd_t   q_cmd,
  output logic                q_pop,
  output logic                init_done,
  output logic                out_valid,
  input  logic                out_ready,
  output tse_pkg::out_item_t  out_data
);

  localparam int unsigned CNT_W = $clog2(MAX_DISTINCT + 1);
  localparam int unsigned IDX_W = $clog2(MAX_DISTINCT);
  localparam int unsigned CMP_W = (CNT_W > 16) ? CNT_W : 16;
  localparam int unsigned RW    = tse_pkg::BMP_ROW_W;
  localparam int unsigned RAW   = tse_pkg::BMP_ROW_AW;
  localparam int unsigned BW    = tse_pkg::BMP_BIT_W;
  localparam int unsigned TW    = tse_pkg::TRI_W;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLR_ROW,
    S_CLR_WR,
    S_BYTE,
    S_CHK,
    S_END
  } state_t;

  logic [RW-1:0] bmp_mem [tse_pkg::BMP_ROWS];
  logic [TW-1:0] list_mem [MAX_DISTINCT];

  state_t             state_r, state_nxt;
  tse_pkg::tse_cmd_t  cmd_r, cmd_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               oversized_r, oversized_nxt;
  logic [CNT_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [RAW-1:0]     init_row_r, init_row_nxt;
  logic               out_valid_r, out_valid_nxt;
  tse_pkg::out_item_t out_data_r, out_data_nxt;

  logic [RW-1:0]  bmp_rd_r;
  logic [TW-1:0]  list_rd_r;
  logic           bmp_re, bmp_we;
  logic [RAW-1:0] bmp_raddr, bmp_waddr;
  logic [RW-1:0]  bmp_wdata;
  logic           list_re, list_we;
  logic [IDX_W-1:0] list_raddr, list_waddr;

  logic           out_free;
  logic           over_limit;
  logic [RAW-1:0] tri_row, clr_row;
  logic [BW-1:0]  tri_bit, clr_bit;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign init_done = (state_r != S_INIT);

  assign out_free   = !out_valid_r || out_ready;
  assign over_limit = (CMP_W'(count_r) >= CMP_W'(distinct_limit)) ||
                      (count_r >= CNT_W'(MAX_DISTINCT));
  assign tri_row    = cmd_r.trigram[TW-1:BW];
  assign tri_bit    = cmd_r.trigram[BW-1:0];
  assign clr_row    = list_rd_r[TW-1:BW];
  assign clr_bit    = list_rd_r[BW-1:0];

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    oversized_nxt = oversized_r;
    clr_idx_nxt   = clr_idx_r;
    init_row_nxt  = init_row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    bmp_re        = 1'b0;
    bmp_we        = 1'b0;
    bmp_raddr     = tri_row;
    bmp_waddr     = tri_row;
    bmp_wdata     = bmp_rd_r;
    list_re       = 1'b0;
    list_we       = 1'b0;
    list_raddr    = '0;
    list_waddr    = count_r[IDX_W-1:0];
    unique case (state_r)
      S_INIT: begin
        bmp_we       = 1'b1;
        bmp_waddr    = init_row_r;
        bmp_wdata    = '0;
        init_row_nxt = init_row_r + 1'b1;
        if (init_row_r == RAW'(tse_pkg::BMP_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.file_start && (count_r != '0)) begin
            list_re     = 1'b1;
            list_raddr  = '0;
            clr_idx_nxt = '0;
            state_nxt   = S_CLR_ROW;
          end else begin
            if (q_cmd.file_start) begin
              oversized_nxt = 1'b0;
            end
            state_nxt = S_BYTE;
          end
        end
      end
      S_CLR_ROW: begin
        bmp_re    = 1'b1;
        bmp_raddr = clr_row;
        state_nxt = S_CLR_WR;
      end
      S_CLR_WR: begin
        bmp_we      = 1'b1;
        bmp_waddr   = clr_row;
        bmp_wdata   = bmp_rd_r & ~(RW'(1) << clr_bit);
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_nxt == count_r) begin
          count_nxt     = '0;
          oversized_nxt = 1'b0;
          state_nxt     = S_BYTE;
        end else begin
          list_re    = 1'b1;
          list_raddr = clr_idx_nxt[IDX_W-1:0];
          state_nxt  = S_CLR_ROW;
        end
      end
      S_BYTE: begin
        if (cmd_r.byte_valid && !oversized_r) begin
          bmp_re    = 1'b1;
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_END;
        end
      end
      S_CHK: begin
        if (bmp_rd_r[tri_bit]) begin
          state_nxt = S_END;
        end else if (over_limit) begin
          oversized_nxt = 1'b1;
          state_nxt     = S_END;
        end else if (out_free) begin
          bmp_we                   = 1'b1;
          bmp_wdata                = bmp_rd_r | (RW'(1) << tri_bit);
          list_we                  = 1'b1;
          count_nxt                = count_r + 1'b1;
          out_valid_nxt            = 1'b1;
          out_data_nxt.trigram     = cmd_r.trigram;
          out_data_nxt.kind        = tse_pkg::KIND_NEW;
          out_data_nxt.last_of_run = !cmd_r.file_end;
          state_nxt                = S_END;
        end
      end
      S_END: begin
        if (!cmd_r.file_end) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.trigram     = '0;
          out_data_nxt.kind        = oversized_r ? tse_pkg::KIND_OVERSIZED
                                                 : tse_pkg::KIND_DONE;
          out_data_nxt.last_of_run = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (bmp_we) begin
      bmp_mem[bmp_waddr] <= bmp_wdata;
    end
    if (bmp_re) begin
      bmp_rd_r <= bmp_mem[bmp_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= cmd_r.trigram;
    end
    if (list_re) begin
      list_rd_r <= list_mem[list_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= '0;
      oversized_r <= 1'b0;
      clr_idx_r   <= '0;
      init_row_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      oversized_r <= oversized_nxt;
      clr_idx_r   <= clr_idx_nxt;
      init_row_r  <= init_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: rtl/core/trigram_set_extractor.sv
// ----------------------------------------------------------------------------
// trigram_set_extractor
// Reports the distinct byte trigrams of each file and its final set status.
// ----------------------------------------------------------------------------
//   channel  ports                         moves
//   in       in_valid/in_ready/in_data     one byte, empty item or file marker
//   out      out_valid/out_ready/out_data  new trigram or file status
//   cfg      cfg_psel..cfg_pready          distinct_limit at address 0
//
// An item passes the back sequencer states S_IDLE, S_BYTE, S_CHK (only with a
// byte) and S_END, paced by the registered bitmap read-modify-write. A file
// start first clears each trigram inserted by the previous file (inserted
// list read, bitmap row read, row write). After reset a clearing pass zeroes
// every bitmap row; in_ready stays low until it ends. Stalls on out hold the
// sequencer; the command queue keeps in open for up to 4 items.
// ----------------------------------------------------------------------------
module trigram_set_extractor #(
  parameter int unsigned MAX_DISTINCT = tse_pkg::MAX_DISTINCT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tse_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tse_pkg::out_item_t          out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tse_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tse_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tse_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  logic [15:0]       distinct_limit_r;
  logic              init_done;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  tse_pkg::tse_cmd_t push_cmd;
  tse_pkg::tse_cmd_t head_cmd;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == tse_pkg::REG_DISTINCT_LIMIT) ?
                      tse_pkg::CFG_DW'(distinct_limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      distinct_limit_r <= tse_pkg::DISTINCT_LIMIT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == tse_pkg::REG_DISTINCT_LIMIT)) begin
      distinct_limit_r <= cfg_pwdata[15:0];
    end
  end

  tse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  tse_back #(
    .MAX_DISTINCT (MAX_DISTINCT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .distinct_limit (distinct_limit_r),
    .q_valid        (q_valid),
    .q_cmd          (head_cmd),
    .q_pop          (q_pop),
    .init_done      (init_done),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

FILE: test/trigram_set_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trigram_set_extractor_tb
// Streams files of bytes into the trigram set extractor and checks every
// reported trigram and file status against a predictor that keeps its own
// window, seen set and distinct count. Directed cases cover the limit, the
// oversized file, empty items and repeated ends; random files follow under
// several limits and handshake idling patterns.
// ----------------------------------------------------------------------------
module trigram_set_extractor_tb;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned SEG_ITEMS    = 165;
  localparam int unsigned NUM_SEGS     = 6;
  localparam int unsigned SETTLE_CYCLES = 20;

  class trigram_scoreboard;
    logic [15:0]  distinct_limit;
    int unsigned  max_distinct;
    logic [15:0]  window;
    bit           seen[bit [tse_pkg::TRI_W-1:0]];
    bit [tse_pkg::TRI_W-1:0] inserted[$];
    int unsigned  distinct_count;
    bit           oversized;
    tse_pkg::out_item_t pending[$];
    int unsigned  mismatches;

    function new(int unsigned cap);
      max_distinct   = cap;
      distinct_limit = tse_pkg::DISTINCT_LIMIT_RST;
      window         = '0;
      distinct_count = 0;
      oversized      = 1'b0;
      mismatches     = 0;
    endfunction

    function void note_input(tse_pkg::in_item_t it);
      tse_pkg::out_item_t res[$];
      tse_pkg::out_item_t r;
      logic [tse_pkg::TRI_W-1:0] gram;
      if (it.file_start) begin
        foreach (inserted[i]) seen.delete(inserted[i]);
        inserted.delete();
        window         = '0;
        distinct_count = 0;
        oversized      = 1'b0;
      end
      if (it.byte_valid && !oversized) begin
        gram   = {window, it.data_byte};
        window = gram[15:0];
        if (!seen.exists(gram)) begin
          if (distinct_count >= distinct_limit || distinct_count >= max_distinct) begin
            oversized = 1'b1;
          end else begin
            seen[gram] = 1'b1;
            inserted = {inserted, gram};
            distinct_count++;
            r.trigram     = gram;
            r.kind        = tse_pkg::KIND_NEW;
            r.last_of_run = 1'b0;
            res = {res, r};
          end
        end
      end
      if (it.file_end) begin
        r.trigram     = '0;
        r.kind        = oversized ? tse_pkg::KIND_OVERSIZED : tse_pkg::KIND_DONE;
        r.last_of_run = 1'b0;
        res = {res, r};
      end
      if (res.size() > 0) res[res.size()-1].last_of_run = 1'b1;
      pending = {pending, res};
    endfunction

    function void check_result(tse_pkg::out_item_t got);
      tse_pkg::out_item_t exp_item;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: trigram %06h kind %0d last %0b",
                   got.trigram, got.kind, got.last_of_run);
      end else begin
        exp_item = pending.pop_front();
        if (got.trigram !== exp_item.trigram || got.kind !== exp_item.kind ||
            got.last_of_run !== exp_item.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected trigram %06h kind %0d last %0b, ",
                      "got trigram %06h kind %0d last %0b"},
                     exp_item.trigram, exp_item.kind, exp_item.last_of_run,
                     got.trigram, got.kind, got.last_of_run);
        end
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  tse_pkg::in_item_t          in_data;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  tse_pkg::out_item_t         out_data;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [tse_pkg::CFG_AW-1:0] cfg_paddr;
  logic [tse_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [tse_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  int unsigned       in_idle_pct;
  int unsigned       out_idle_pct;
  int unsigned       cycles;

  trigram_scoreboard sb = new(tse_pkg::MAX_DISTINCT_DEF);

  trigram_set_extractor uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic v, input logic s,
                           input logic e);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data.data_byte  <= b;
    in_data.byte_valid <= v;
    in_data.file_start <= s;
    in_data.file_end   <= e;
    do @(posedge clk); while (!in_ready);
  endtask

  // the last item before a drain always carries file_end, so an empty queue
  // means the sequencer has gone idle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] lim);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= tse_pkg::REG_DISTINCT_LIMIT;
    cfg_pwdata  <= tse_pkg::CFG_DW'(lim);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.distinct_limit = lim;
  endtask

  initial begin
    logic [15:0] seg_limit [NUM_SEGS];
    int unsigned sent;
    int unsigned file_len;
    bit          narrow;
    logic [7:0]  b;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    cycles       = 0;
    in_idle_pct  = 30;
    out_idle_pct = 64;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // bytes before any file start, empty items, repeated ends
    send_item(8'hFF, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'hA5, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    send_item(8'hA5, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'h7E, 1'b1, 1'b1, 1'b1);
    send_item(8'h55, 1'b0, 1'b1, 1'b1);
    drain;

    // limit hit mid-file, later bytes ignored
    write_limit(16'd2);
    send_item(8'h01, 1'b1, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0, 1'b0);
    send_item(8'h03, 1'b1, 1'b0, 1'b0);
    send_item(8'h04, 1'b1, 1'b0, 1'b0);
    send_item(8'h04, 1'b1, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    drain;

    write_limit(16'd0);
    send_item(8'h80, 1'b1, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    drain;

    seg_limit = '{16'hFFFF, 16'd3, 16'd0, 16'd24, 16'd1, 16'd0};
    seg_limit[NUM_SEGS-1] = 16'($urandom_range(2, 60));

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      in_idle_pct  = (seg < 2) ? 30 : (seg < 4) ? 64 : 0;
      out_idle_pct = (seg < 2) ? 64 : (seg < 4) ? 30 : 0;
      write_limit(seg_limit[seg]);
      sent = 0;
      while (sent < SEG_ITEMS) begin
        if ($urandom_range(0, 99) < 85) begin
          file_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                                 : $urandom_range(1, 40);
          narrow   = $urandom_range(0, 1);
          for (int i = 0; i < file_len; i++) begin
            b = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom);
            send_item(b, $urandom_range(0, 9) != 0, i == 0, i == file_len - 1);
            sent++;
          end
        end else begin
          send_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
          sent++;
        end
      end
      send_item(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
      drain;
    end

    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
